/* src/stq_pkg.sv */
package stq_pkg;

    localparam int TIME_W  = 32;
    localparam int OP_W    = 3;
    localparam int ID_W    = 3;
    localparam int PIDX_W  = 3;
    localparam int PCNT_W  = 8;
    localparam int IVL_W   = 16;
    localparam int MAX_EXP = 8;
    localparam int FW      = $clog2(MAX_EXP);

    localparam logic [IVL_W-1:0] IVL_SAT = '1;

    localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
    localparam logic [OP_W-1:0] OP_START_REL = 3'd1;
    localparam logic [OP_W-1:0] OP_START_ABS = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP      = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_REJECT   = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] expiry;
    } t_entry;

    // divide ratio minus one
    function automatic logic [PCNT_W-1:0] ratio_m1(input logic [PIDX_W-1:0] idx);
        logic [PCNT_W-1:0] r;
        unique case (idx)
            3'd0: r = 8'd0;
            3'd1: r = 8'd1;
            3'd2: r = 8'd3;
            3'd3: r = 8'd7;
            3'd4: r = 8'd15;
            3'd5: r = 8'd31;
            3'd6: r = 8'd63;
            3'd7: r = 8'd255;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

/* src/stq_ifs.sv */
interface stq_cmd_if;
    import stq_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   slot;
    logic [TIME_W-1:0] ticks;
    modport source (output valid, op, slot, ticks, input ready);
    modport sink   (input valid, op, slot, ticks, output ready);
endinterface

interface stq_res_if;
    import stq_pkg::*;
    logic              valid;
    logic              ready;
    logic              kind;
    logic              status;
    logic [ID_W-1:0]   expired_slot;
    logic [TIME_W-1:0] current_time;
    logic [IVL_W-1:0]  next_interval;
    logic              last;
    modport source (output valid, kind, status, expired_slot, current_time, next_interval,
                    last, input ready);
    modport sink   (input valid, kind, status, expired_slot, current_time, next_interval,
                    last, output ready);
endinterface

interface stq_cfg_if;
    import stq_pkg::*;
    logic              valid;
    logic              ready;
    logic [PIDX_W-1:0] prescale_index;
    modport source (output valid, prescale_index, input ready);
    modport sink   (input valid, prescale_index, output ready);
endinterface

/* src/stq_ram.sv */
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* src/stq_alu.sv */
module stq_alu (
    input  logic [stq_pkg::TIME_W-1:0] i_a,
    input  logic [stq_pkg::TIME_W-1:0] i_b,
    input  logic                       i_sub,
    output logic [stq_pkg::TIME_W-1:0] o_y
);
    import stq_pkg::*;

    logic [TIME_W-1:0] b_op;

    assign b_op = i_sub ? ~i_b : i_b;
    assign o_y  = i_a + b_op + TIME_W'(i_sub);

endmodule

/* src/sorted_timer_expiry_queue_core.sv */
// Channel  Dir  Payload                                                   Request taken when
// i_cmd    in   op, slot, ticks                                           valid & ready
// o_res    out  kind, status, expired_slot, current_time, next_interval,  valid & ready
//               last
// i_cfg    in   prescale_index                                            valid & ready
//
// One request at a time; i_cmd.ready is high only while the sequencer is idle.
// Queue lives in a ring RAM with registered read; one shared add/subtract unit does
// every expiry compare. Tick pops expired slots, then reads the head. Start scans for
// its place and moves later entries up; Stop scans for the slot and moves later ones
// down. Then the results go out in order, held while o_res stalls.
// i_rst_n is synchronous, active low; no clearing pass is needed after reset.
module sorted_timer_expiry_queue_core #(
    parameter int TIMER_SLOTS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stq_cmd_if.sink   i_cmd,
    stq_res_if.source o_res,
    stq_cfg_if.sink   i_cfg
);
    import stq_pkg::*;

    localparam int IW = $clog2(TIMER_SLOTS);
    localparam int LW = $clog2(TIMER_SLOTS + 1);
    localparam int SW = LW + 1;
    localparam int EW = $bits(t_entry);

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_POP_RD  = 15'b000000000000010,
        S_POP_EV  = 15'b000000000000100,
        S_HEAD_RD = 15'b000000000001000,
        S_HEAD_EV = 15'b000000000010000,
        S_INS_RD  = 15'b000000000100000,
        S_INS_EV  = 15'b000000001000000,
        S_SHF_RD  = 15'b000000010000000,
        S_SHF_WR  = 15'b000000100000000,
        S_INS_WR  = 15'b000001000000000,
        S_STP_RD  = 15'b000010000000000,
        S_STP_EV  = 15'b000100000000000,
        S_DEL_RD  = 15'b001000000000000,
        S_DEL_WR  = 15'b010000000000000,
        S_EMIT    = 15'b100000000000000
    } t_state;

    function automatic logic [IW-1:0] ring_addr(input logic [IW-1:0] head,
                                                input logic [LW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(off);
        if (sum >= SW'(TIMER_SLOTS)) begin
            sum = sum - SW'(TIMER_SLOTS);
        end
        return sum[IW-1:0];
    endfunction

    t_state              r_state,  n_state;
    logic [TIME_W-1:0]   r_time,   n_time;
    logic [PCNT_W-1:0]   r_pcnt,   n_pcnt;
    logic [PIDX_W-1:0]   r_pidx,   n_pidx;
    logic [IW-1:0]       r_head,   n_head;
    logic [LW-1:0]       r_len,    n_len;
    logic [TIMER_SLOTS-1:0] r_armed, n_armed;
    logic                r_ovalid, n_ovalid;

    logic [ID_W-1:0]     r_slot,   n_slot;
    logic [TIME_W-1:0]   r_expiry, n_expiry;
    logic                r_st,     n_st;
    logic [LW-1:0]       r_pos,    n_pos;
    logic [LW-1:0]       r_idx,    n_idx;
    logic [ID_W-1:0]     r_fired [MAX_EXP];
    logic [ID_W-1:0]     n_fired [MAX_EXP];
    logic [FW:0]         r_nfired, n_nfired;
    logic [FW:0]         r_k,      n_k;
    logic [IVL_W-1:0]    r_ival,   n_ival;
    logic                r_okind,  n_okind;
    logic                r_ostat,  n_ostat;
    logic [ID_W-1:0]     r_oslot,  n_oslot;
    logic [TIME_W-1:0]   r_otime,  n_otime;
    logic [IVL_W-1:0]    r_oival,  n_oival;
    logic                r_olast,  n_olast;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic [IW-1:0]       ram_raddr;
    logic [EW-1:0]       ram_wdata;
    logic [EW-1:0]       ram_rdata;
    t_entry              rd;

    logic [TIME_W-1:0]   alu_a;
    logic [TIME_W-1:0]   alu_b;
    logic                alu_sub;
    logic [TIME_W-1:0]   alu_y;

    logic                slot_ok;
    logic [IW-1:0]       slot_idx;
    logic                reject;
    logic                out_free;
    logic                due;

    stq_ram #(
        .WIDTH (EW),
        .DEPTH (TIMER_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    stq_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_y   (alu_y)
    );

    assign rd       = t_entry'(ram_rdata);
    assign slot_ok  = 32'(i_cmd.slot) < 32'(TIMER_SLOTS);
    assign slot_idx = IW'(i_cmd.slot);
    assign reject   = !slot_ok || r_armed[slot_idx] || (r_len >= LW'(TIMER_SLOTS));
    assign out_free = !r_ovalid || o_res.ready;
    // head due when time - expiry is non-negative, i.e. expiry - time is zero or negative
    // but not the most negative value
    assign due      = (alu_y == '0) || (alu_y[TIME_W-1] && (alu_y[TIME_W-2:0] != '0));

    assign i_cmd.ready         = (r_state == S_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_res.valid         = r_ovalid;
    assign o_res.kind          = r_okind;
    assign o_res.status        = r_ostat;
    assign o_res.expired_slot  = r_oslot;
    assign o_res.current_time  = r_otime;
    assign o_res.next_interval = r_oival;
    assign o_res.last          = r_olast;

    always_comb begin
        n_state  = r_state;
        n_time   = r_time;
        n_pcnt   = r_pcnt;
        n_pidx   = r_pidx;
        n_head   = r_head;
        n_len    = r_len;
        n_armed  = r_armed;
        n_ovalid = r_ovalid && !o_res.ready;
        n_slot   = r_slot;
        n_expiry = r_expiry;
        n_st     = r_st;
        n_pos    = r_pos;
        n_idx    = r_idx;
        n_fired  = r_fired;
        n_nfired = r_nfired;
        n_k      = r_k;
        n_ival   = r_ival;
        n_okind  = r_okind;
        n_ostat  = r_ostat;
        n_oslot  = r_oslot;
        n_otime  = r_otime;
        n_oival  = r_oival;
        n_olast  = r_olast;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        alu_a     = r_time;
        alu_b     = TIME_W'(1);
        alu_sub   = 1'b0;

        if (i_cfg.valid) begin
            n_pidx = i_cfg.prescale_index;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.op != OP_TICK) begin
                    alu_b = i_cmd.ticks;
                end
                if (i_cmd.valid) begin
                    n_st     = ST_OK;
                    n_nfired = '0;
                    n_k      = '0;
                    n_pos    = '0;
                    n_slot   = i_cmd.slot;
                    n_state  = S_HEAD_RD;
                    unique case (i_cmd.op)
                        OP_TICK: begin
                            if (r_pcnt >= ratio_m1(r_pidx)) begin
                                n_pcnt = '0;
                                n_time = alu_y;
                            end else begin
                                n_pcnt = r_pcnt + 1'b1;
                            end
                            n_state = S_POP_RD;
                        end
                        OP_START_REL: begin
                            n_expiry = alu_y;
                            if ((i_cmd.ticks == '0) || reject) begin
                                n_st = ST_REJECT;
                            end else begin
                                n_state = S_INS_RD;
                            end
                        end
                        OP_START_ABS: begin
                            n_expiry = i_cmd.ticks;
                            if (reject) begin
                                n_st = ST_REJECT;
                            end else begin
                                n_state = S_INS_RD;
                            end
                        end
                        OP_STOP: begin
                            if (slot_ok && r_armed[slot_idx]) begin
                                n_armed[slot_idx] = 1'b0;
                                n_state           = S_STP_RD;
                            end
                        end
                        OP_CLEAR: begin
                            n_len   = '0;
                            n_armed = '0;
                        end
                        default: begin
                            n_st = ST_REJECT;
                        end
                    endcase
                end
            end

            S_POP_RD: begin
                if ((r_len == '0) || (r_nfired == (FW + 1)'(MAX_EXP))) begin
                    n_state = S_HEAD_RD;
                end else begin
                    ram_raddr = r_head;
                    n_state   = S_POP_EV;
                end
            end

            S_POP_EV: begin
                alu_a   = r_time;
                alu_b   = rd.expiry;
                alu_sub = 1'b1;
                if (!alu_y[TIME_W-1]) begin
                    n_fired[r_nfired[FW-1:0]] = rd.id;
                    n_nfired                  = r_nfired + 1'b1;
                    n_armed[IW'(rd.id)]       = 1'b0;
                    n_head                    = ring_addr(r_head, LW'(1));
                    n_len                     = r_len - 1'b1;
                    n_state                   = S_POP_RD;
                end else begin
                    n_state = S_HEAD_RD;
                end
            end

            S_HEAD_RD: begin
                if (r_len == '0) begin
                    n_ival  = IVL_SAT;
                    n_state = S_EMIT;
                end else begin
                    ram_raddr = r_head;
                    n_state   = S_HEAD_EV;
                end
            end

            S_HEAD_EV: begin
                alu_a   = rd.expiry;
                alu_b   = r_time;
                alu_sub = 1'b1;
                if (due) begin
                    n_ival = '0;
                end else if (alu_y[TIME_W-1:IVL_W] != '0) begin
                    n_ival = IVL_SAT;
                end else begin
                    n_ival = alu_y[IVL_W-1:0];
                end
                n_state = S_EMIT;
            end

            S_INS_RD: begin
                if (r_pos == r_len) begin
                    n_idx   = r_len;
                    n_state = S_SHF_RD;
                end else begin
                    ram_raddr = ring_addr(r_head, r_pos);
                    n_state   = S_INS_EV;
                end
            end

            S_INS_EV: begin
                alu_a   = r_expiry;
                alu_b   = rd.expiry;
                alu_sub = 1'b1;
                if (!alu_y[TIME_W-1]) begin
                    n_pos   = r_pos + 1'b1;
                    n_state = S_INS_RD;
                end else begin
                    n_idx   = r_len;
                    n_state = S_SHF_RD;
                end
            end

            S_SHF_RD: begin
                if (r_idx == r_pos) begin
                    n_state = S_INS_WR;
                end else begin
                    ram_raddr = ring_addr(r_head, r_idx - 1'b1);
                    n_state   = S_SHF_WR;
                end
            end

            S_SHF_WR: begin
                ram_we    = 1'b1;
                ram_waddr = ring_addr(r_head, r_idx);
                ram_wdata = ram_rdata;
                n_idx     = r_idx - 1'b1;
                n_state   = S_SHF_RD;
            end

            S_INS_WR: begin
                ram_we               = 1'b1;
                ram_waddr            = ring_addr(r_head, r_pos);
                ram_wdata            = EW'({r_slot, r_expiry});
                n_len                = r_len + 1'b1;
                n_armed[IW'(r_slot)] = 1'b1;
                n_state              = S_HEAD_RD;
            end

            S_STP_RD: begin
                if (r_pos == r_len) begin
                    n_state = S_HEAD_RD;
                end else begin
                    ram_raddr = ring_addr(r_head, r_pos);
                    n_state   = S_STP_EV;
                end
            end

            S_STP_EV: begin
                if (rd.id == r_slot) begin
                    n_idx   = r_pos;
                    n_state = S_DEL_RD;
                end else begin
                    n_pos   = r_pos + 1'b1;
                    n_state = S_STP_RD;
                end
            end

            S_DEL_RD: begin
                if (LW'(r_idx + 1'b1) == r_len) begin
                    n_len   = r_len - 1'b1;
                    n_state = S_HEAD_RD;
                end else begin
                    ram_raddr = ring_addr(r_head, LW'(r_idx + 1'b1));
                    n_state   = S_DEL_WR;
                end
            end

            S_DEL_WR: begin
                ram_we    = 1'b1;
                ram_waddr = ring_addr(r_head, r_idx);
                ram_wdata = ram_rdata;
                n_idx     = r_idx + 1'b1;
                n_state   = S_DEL_RD;
            end

            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_otime  = r_time;
                    n_oival  = r_ival;
                    if (r_k == r_nfired) begin
                        n_okind = KIND_STATUS;
                        n_ostat = r_st;
                        n_oslot = '0;
                        n_olast = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_okind = KIND_EXPIRY;
                        n_ostat = ST_OK;
                        n_oslot = r_fired[r_k[FW-1:0]];
                        n_olast = 1'b0;
                        n_k     = r_k + 1'b1;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_time   <= '0;
            r_pcnt   <= '0;
            r_pidx   <= '0;
            r_head   <= '0;
            r_len    <= '0;
            r_armed  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_time   <= n_time;
            r_pcnt   <= n_pcnt;
            r_pidx   <= n_pidx;
            r_head   <= n_head;
            r_len    <= n_len;
            r_armed  <= n_armed;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot   <= n_slot;
        r_expiry <= n_expiry;
        r_st     <= n_st;
        r_pos    <= n_pos;
        r_idx    <= n_idx;
        r_fired  <= n_fired;
        r_nfired <= n_nfired;
        r_k      <= n_k;
        r_ival   <= n_ival;
        r_okind  <= n_okind;
        r_ostat  <= n_ostat;
        r_oslot  <= n_oslot;
        r_otime  <= n_otime;
        r_oival  <= n_oival;
        r_olast  <= n_olast;
    end

endmodule

/* dv/stq_expiry_checker.sv */
module stq_expiry_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    stq_cmd_if   i_cmd,
    stq_res_if   i_res,
    stq_cfg_if   i_cfg,
    output int   o_mismatches,
    output int   o_pending,
    output int   o_requests_seen,
    output int   o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import stq_pkg::*;

    localparam int SLOTS = 8;
    localparam int DIVIDE [8] = '{1, 2, 4, 8, 16, 32, 64, 256};

    typedef struct packed {
        logic              kind;
        logic              status;
        logic [ID_W-1:0]   slot;
        logic [TIME_W-1:0] stamp;
        logic [IVL_W-1:0]  gap;
        logic              last;
    } t_timer_event;

    // timer state as the block should hold it
    logic [PIDX_W-1:0] divide_sel;
    logic [PCNT_W-1:0] prescaler;
    logic [TIME_W-1:0] now_count;
    logic [ID_W-1:0]   q_slot [SLOTS];
    logic [TIME_W-1:0] q_expiry [SLOTS];
    int                depth;
    logic [SLOTS-1:0]  armed;

    t_timer_event awaited [$];
    int           mismatch_cnt;
    int           request_cnt;
    int           result_cnt;

    task automatic log_mismatch(input string msg);
        mismatch_cnt++;
        $display("%0t MISMATCH result %0d: %s", $realtime, result_cnt, msg);
    endtask

    function automatic logic has_come(input logic [TIME_W-1:0] expiry);
        logic [TIME_W-1:0] d;
        d = now_count - expiry;
        return !d[TIME_W-1];
    endfunction

    function automatic void drop_entry(input int pos);
        int i;
        for (i = pos; i + 1 < depth; i++) begin
            q_slot[i]   = q_slot[i+1];
            q_expiry[i] = q_expiry[i+1];
        end
        depth--;
    endfunction

    // sorted insert, equal expiries stay in arrival order
    function automatic logic enqueue(input logic [ID_W-1:0] s, input logic [TIME_W-1:0] expiry);
        int pos;
        int i;
        logic [TIME_W-1:0] d;
        if (armed[s] || depth >= SLOTS) begin
            return ST_REJECT;
        end
        pos = 0;
        while (pos < depth) begin
            d = expiry - q_expiry[pos];
            if (d[TIME_W-1]) begin
                break;
            end
            pos++;
        end
        for (i = depth; i > pos; i--) begin
            q_slot[i]   = q_slot[i-1];
            q_expiry[i] = q_expiry[i-1];
        end
        q_slot[pos]   = s;
        q_expiry[pos] = expiry;
        depth++;
        armed[s] = 1'b1;
        return ST_OK;
    endfunction

    task automatic apply_timer_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] slot,
                                       input logic [TIME_W-1:0] ticks);
        logic [ID_W-1:0]   fired [MAX_EXP];
        int                n_fired;
        int                i;
        logic              verdict;
        logic [TIME_W-1:0] d;
        logic [IVL_W-1:0]  gap;
        t_timer_event      ev;
        n_fired = 0;
        verdict = ST_OK;
        case (op)
            OP_TICK: begin
                if (int'(prescaler) + 1 >= DIVIDE[divide_sel]) begin
                    prescaler = '0;
                    now_count = now_count + 1'b1;
                end else begin
                    prescaler = prescaler + 1'b1;
                end
                while (n_fired < MAX_EXP && depth > 0 && has_come(q_expiry[0])) begin
                    fired[n_fired] = q_slot[0];
                    n_fired++;
                    armed[q_slot[0]] = 1'b0;
                    drop_entry(0);
                end
            end
            OP_START_REL: begin
                if (ticks == '0) begin
                    verdict = ST_REJECT;
                end else begin
                    verdict = enqueue(slot, now_count + ticks);
                end
            end
            OP_START_ABS: begin
                verdict = enqueue(slot, ticks);
            end
            OP_STOP: begin
                if (armed[slot]) begin
                    for (i = 0; i < depth; i++) begin
                        if (q_slot[i] == slot) begin
                            drop_entry(i);
                            break;
                        end
                    end
                    armed[slot] = 1'b0;
                end
            end
            OP_CLEAR: begin
                depth = 0;
                armed = '0;
            end
            default: begin
                verdict = ST_REJECT;
            end
        endcase

        if (depth == 0) begin
            gap = IVL_SAT;
        end else if (has_come(q_expiry[0])) begin
            gap = '0;
        end else begin
            d = q_expiry[0] - now_count;
            gap = (d > TIME_W'(IVL_SAT)) ? IVL_SAT : d[IVL_W-1:0];
        end

        for (i = 0; i < n_fired; i++) begin
            ev.kind   = KIND_EXPIRY;
            ev.status = ST_OK;
            ev.slot   = fired[i];
            ev.stamp  = now_count;
            ev.gap    = gap;
            ev.last   = 1'b0;
            awaited.push_back(ev);
        end
        ev.kind   = KIND_STATUS;
        ev.status = verdict;
        ev.slot   = '0;
        ev.stamp  = now_count;
        ev.gap    = gap;
        ev.last   = 1'b1;
        awaited.push_back(ev);
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] got,
                               input logic [TIME_W-1:0] want);
        if (got !== want) begin
            log_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    task automatic check_result();
        t_timer_event want;
        if (awaited.size() == 0) begin
            log_mismatch($sformatf("unexpected result kind %0b slot %0d time %0h",
                                   i_res.kind, i_res.expired_slot, i_res.current_time));
            return;
        end
        want = awaited.pop_front();
        check_field("kind", TIME_W'(i_res.kind), TIME_W'(want.kind));
        check_field("status", TIME_W'(i_res.status), TIME_W'(want.status));
        check_field("expired_slot", TIME_W'(i_res.expired_slot), TIME_W'(want.slot));
        check_field("current_time", i_res.current_time, want.stamp);
        check_field("next_interval", TIME_W'(i_res.next_interval), TIME_W'(want.gap));
        check_field("last", TIME_W'(i_res.last), TIME_W'(want.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            divide_sel = '0;
            prescaler  = '0;
            now_count  = '0;
            depth      = 0;
            armed      = '0;
            awaited.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                divide_sel = i_cfg.prescale_index;
            end
            if (i_res.valid && i_res.ready) begin
                check_result();
                result_cnt++;
            end
            if (i_cmd.valid && i_cmd.ready) begin
                apply_timer_request(i_cmd.op, i_cmd.slot, i_cmd.ticks);
                request_cnt++;
            end
        end
        o_pending       <= awaited.size();
        o_mismatches    <= mismatch_cnt;
        o_requests_seen <= request_cnt;
        o_results_seen  <= result_cnt;
    end

endmodule

/* dv/sorted_timer_expiry_queue_core_tb.sv */
module sorted_timer_expiry_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import stq_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;

    logic i_clk;
    logic i_rst_n;

    stq_cmd_if cmd_ch ();
    stq_res_if res_ch ();
    stq_cfg_if cfg_ch ();

    int   tx_idle_pct;
    int   rx_idle_pct;
    logic rx_hold;
    logic long_stall_go;

    int mismatches;
    int pending;
    int requests_seen;
    int results_seen;

    sorted_timer_expiry_queue_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    stq_expiry_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd_ch),
        .i_res           (res_ch),
        .i_cfg           (cfg_ch),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_requests_seen (requests_seen),
        .o_results_seen  (results_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    always @(posedge i_clk) begin
        res_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // long output stall while requests keep coming
    initial begin
        rx_hold <= 1'b0;
        wait (long_stall_go);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] slot,
                                input logic [TIME_W-1:0] ticks);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.op    <= op;
        cmd_ch.slot  <= slot;
        cmd_ch.ticks <= ticks;
        do @(posedge i_clk); while (!cmd_ch.ready);
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_divider(input logic [PIDX_W-1:0] sel);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.prescale_index <= sel;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_random_request();
        int                pick;
        int                shape;
        logic [TIME_W-1:0] ticks;
        pick  = $urandom_range(0, 99);
        shape = $urandom_range(0, 9);
        if (pick < 47) begin
            send_request(OP_TICK, ID_W'($urandom), $urandom);
        end else if (pick < 71) begin
            if (shape == 0) begin
                ticks = '0;
            end else if (shape == 1) begin
                ticks = $urandom;
            end else begin
                ticks = $urandom_range(1, 24);
            end
            send_request(OP_START_REL, ID_W'($urandom), ticks);
        end else if (pick < 83) begin
            ticks = (shape == 0) ? TIME_W'($urandom) : TIME_W'($urandom_range(0, 300));
            send_request(OP_START_ABS, ID_W'($urandom), ticks);
        end else if (pick < 96) begin
            send_request(OP_STOP, ID_W'($urandom), $urandom);
        end else if (pick < 98) begin
            send_request(OP_CLEAR, ID_W'($urandom), $urandom);
        end else begin
            send_request(OP_W'($urandom_range(5, 7)), ID_W'($urandom), $urandom);
        end
    endtask

    initial begin
        int tx_profile [3];
        int rx_profile [3];
        int dividers [6];
        int ph;
        int half;
        int n;
        int s;
        tx_profile = '{7, 66, 0};
        rx_profile = '{66, 7, 0};
        dividers   = '{1, 7, 2, 0, 5, 3};

        i_rst_n               <= 1'b0;
        cmd_ch.valid          <= 1'b0;
        cmd_ch.op             <= OP_TICK;
        cmd_ch.slot           <= '0;
        cmd_ch.ticks          <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.prescale_index <= '0;
        rx_idle_pct           <= 0;
        tx_idle_pct   = 0;
        long_stall_go = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests, divide by one
        write_divider(3'd0);
        send_request(OP_TICK, 3'd0, 32'd0);
        send_request(OP_START_REL, 3'd0, 32'd0);
        send_request(OP_START_REL, 3'd0, 32'd1);
        send_request(OP_START_REL, 3'd0, 32'd5);
        send_request(OP_START_ABS, 3'd1, 32'hFFFF_FFFF);
        send_request(OP_START_ABS, 3'd2, 32'd2);
        send_request(OP_START_ABS, 3'd3, 32'h8000_0001);
        send_request(OP_STOP, 3'd5, 32'd0);
        send_request(OP_TICK, 3'd0, 32'd0);
        send_request(OP_STOP, 3'd3, 32'd0);
        send_request(OP_START_REL, 3'd4, 32'hFFFF_FFFF);
        send_request(3'd5, 3'd7, 32'hFFFF_FFFF);
        send_request(3'd6, 3'd7, 32'hFFFF_FFFF);
        send_request(3'd7, 3'd7, 32'hFFFF_FFFF);
        send_request(OP_TICK, 3'd7, 32'hFFFF_FFFF);
        for (s = 0; s < 8; s++) begin
            send_request(OP_START_REL, ID_W'(s), 32'd1);
        end
        send_request(OP_TICK, 3'd0, 32'd0);
        send_request(OP_START_ABS, 3'd6, 32'd0);
        send_request(OP_CLEAR, 3'd0, 32'd0);
        drain();

        for (ph = 0; ph < 3; ph++) begin
            tx_idle_pct = tx_profile[ph];
            rx_idle_pct <= rx_profile[ph];
            for (half = 0; half < 2; half++) begin
                write_divider(PIDX_W'(dividers[ph*2+half]));
                for (n = 0; n < 50; n++) begin
                    if (ph == 2 && half == 0 && n == 10) begin
                        long_stall_go = 1'b1;
                    end
                    send_random_request();
                end
                drain();
            end
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("summary: %0d requests, %0d results compared, %0d mismatches", requests_seen,
                 results_seen, mismatches);
        $display("summary: divide ratios 1 to 256, three idle profiles, one long output stall");
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* files.f */
src/stq_pkg.sv
src/stq_ifs.sv
src/stq_ram.sv
src/stq_alu.sv
src/sorted_timer_expiry_queue_core.sv
dv/stq_expiry_checker.sv
dv/sorted_timer_expiry_queue_core_tb.sv
